>>> rtl/pme_pkg.sv
// ----------------------------------------------------------------------------
// pme_pkg
// Shared types, codes and fixed-point helpers for the point mass integrator.
// ----------------------------------------------------------------------------
package pme_pkg;

  localparam int TRAIL_DEPTH = 100;
  localparam int TRAIL_AW = (TRAIL_DEPTH > 1) ? $clog2(TRAIL_DEPTH) : 1;
  localparam int TRAIL_CW = $clog2(TRAIL_DEPTH + 1);
  localparam int IDX_W = 7;
  localparam int SLOT_SW = ((TRAIL_CW > IDX_W) ? TRAIL_CW : IDX_W) + 1;
  localparam int TRAIL_W = 144;

  typedef enum logic [1:0] {
    CMD_FORCE   = 2'd0,
    CMD_STEP    = 2'd1,
    CMD_READ    = 2'd2,
    CMD_RESTART = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_SKIP  = 2'd1,
    ST_RANGE = 2'd2,
    ST_SAT   = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    REG_POS_X  = 3'd0,
    REG_POS_Y  = 3'd1,
    REG_POS_Z  = 3'd2,
    REG_VEL_X  = 3'd3,
    REG_VEL_Y  = 3'd4,
    REG_VEL_Z  = 3'd5,
    REG_MASS   = 3'd6,
    REG_ACTIVE = 3'd7
  } reg_idx_t;

  typedef struct packed {
    logic done;
    logic sat;
  } lane_stat_t;

  localparam logic [49:0] CAP49 = 50'd1 << 49;

  // min((a*b) >> 16, 2^49) from the two 32-bit partial products
  function automatic logic [49:0] mulcap(input logic [63:0] lo, input logic [63:0] hi);
    logic [49:0] r;
    r = {1'b0, hi[32:0], 16'd0} + {2'b0, lo[63:16]};
    if (hi[63:33] != '0) return CAP49;
    if (r > CAP49) return CAP49;
    return r;
  endfunction

  function automatic logic signed [47:0] sat48(input logic signed [51:0] x);
    if (x > 52'sh7FFFFFFFFFFF) return 48'sh7FFFFFFFFFFF;
    if (x < -52'sh800000000000) return 48'sh800000000000;
    return x[47:0];
  endfunction

  function automatic logic is_sat48(input logic signed [51:0] x);
    return (x > 52'sh7FFFFFFFFFFF) || (x < -52'sh800000000000);
  endfunction

  function automatic logic [47:0] mag48(input logic signed [47:0] x);
    return x[47] ? 48'(-x) : 48'(x);
  endfunction

endpackage

>>> rtl/pme_ifs.sv
// ----------------------------------------------------------------------------
// pme channel interfaces
// Command, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface pme_cmd_if;
  logic              valid;
  logic              ready;
  logic [1:0]        command;
  logic signed [47:0] force_x;
  logic signed [47:0] force_y;
  logic signed [47:0] force_z;
  logic [31:0]       time_step;
  logic [6:0]        trail_index;
  modport source (output valid, command, force_x, force_y, force_z, time_step,
                  trail_index, input ready);
  modport sink (input valid, command, force_x, force_y, force_z, time_step,
                trail_index, output ready);
endinterface

interface pme_res_if;
  logic              valid;
  logic              ready;
  logic signed [47:0] pos_x;
  logic signed [47:0] pos_y;
  logic signed [47:0] pos_z;
  logic signed [47:0] vel_x;
  logic signed [47:0] vel_y;
  logic signed [47:0] vel_z;
  logic [6:0]        trail_count;
  logic [1:0]        status;
  modport source (output valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  trail_count, status, input ready);
  modport sink (input valid, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                trail_count, status, output ready);
endinterface

interface pme_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [47:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/pme_ram.sv
// ----------------------------------------------------------------------------
// pme_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/pme_lane.sv
// ----------------------------------------------------------------------------
// pme_lane
// One axis: serial divide F/m, then two shared-multiplier updates of v and p.
// ----------------------------------------------------------------------------
module pme_lane (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic signed [47:0]  force_in,
  input  logic signed [47:0]  vel_in,
  input  logic signed [47:0]  pos_in,
  input  logic [47:0]         mass,
  input  logic [31:0]         dt,
  output logic signed [47:0]  vel_out,
  output logic signed [47:0]  pos_out,
  output pme_pkg::lane_stat_t stat
);
  typedef enum logic [7:0] {
    L_IDLE = 8'b0000_0001,
    L_DIV  = 8'b0000_0010,
    L_MLO  = 8'b0000_0100,
    L_MHI  = 8'b0000_1000,
    L_VEL  = 8'b0001_0000,
    L_PLO  = 8'b0010_0000,
    L_PHI  = 8'b0100_0000,
    L_POS  = 8'b1000_0000
  } lstate_t;

  lstate_t     state;
  logic [5:0]  cnt;
  logic [63:0] num;
  logic [47:0] rem;
  logic [47:0] m_r;
  logic [31:0] dt_r;
  logic        neg_f;
  logic [63:0] lo_p;
  logic [63:0] hi_p;
  logic        done;
  logic        sat;

  logic [48:0] trial;
  logic        ge;
  logic [63:0] amag;
  logic [63:0] vmag;
  logic [63:0] src;
  logic [31:0] half;
  logic [63:0] prod;
  logic [49:0] dmag;
  logic signed [51:0] sdel;
  logic signed [51:0] base;
  logic signed [51:0] sum;
  logic        use_neg;

  assign trial = {rem, num[63]};
  assign ge    = trial >= {1'b0, m_r};
  // zero mass means no acceleration
  assign amag  = (m_r == '0) ? '0 : num;
  assign vmag  = {16'd0, pme_pkg::mag48(vel_out)};
  assign src   = (state == L_PLO || state == L_PHI) ? vmag : amag;
  assign half  = (state == L_MHI || state == L_PHI) ? src[63:32] : src[31:0];
  assign prod  = half * dt_r;
  assign dmag  = pme_pkg::mulcap(lo_p, hi_p);
  assign use_neg = (state == L_POS) ? vel_out[47] : neg_f;
  assign sdel  = use_neg ? -$signed({2'b00, dmag}) : $signed({2'b00, dmag});
  assign base  = (state == L_POS) ? 52'(pos_out) : 52'(vel_out);
  assign sum   = base + sdel;

  assign stat.done = done;
  assign stat.sat  = sat;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done  <= 1'b0;
      sat   <= 1'b0;
    end else begin
      done <= (state == L_POS);
      unique case (state)
        L_IDLE: begin
          if (start) begin
            num     <= {pme_pkg::mag48(force_in), 16'd0};
            rem     <= '0;
            cnt     <= '0;
            m_r     <= mass;
            dt_r    <= dt;
            neg_f   <= force_in[47];
            vel_out <= vel_in;
            pos_out <= pos_in;
            sat     <= 1'b0;
            state   <= L_DIV;
          end
        end
        L_DIV: begin
          rem <= ge ? 48'(trial - {1'b0, m_r}) : trial[47:0];
          num <= {num[62:0], ge};
          cnt <= cnt + 6'd1;
          if (cnt == 6'd63) state <= L_MLO;
        end
        L_MLO: begin
          lo_p  <= prod;
          state <= L_MHI;
        end
        L_MHI: begin
          hi_p  <= prod;
          state <= L_VEL;
        end
        L_VEL: begin
          vel_out <= pme_pkg::sat48(sum);
          sat     <= sat | pme_pkg::is_sat48(sum);
          state   <= L_PLO;
        end
        L_PLO: begin
          lo_p  <= prod;
          state <= L_PHI;
        end
        L_PHI: begin
          hi_p  <= prod;
          state <= L_POS;
        end
        L_POS: begin
          pos_out <= pme_pkg::sat48(sum);
          sat     <= sat | pme_pkg::is_sat48(sum);
          state   <= L_IDLE;
        end
        default: state <= L_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/point_mass_euler_integrator.sv
// ----------------------------------------------------------------------------
// point_mass_euler_integrator
// Semi-implicit Euler integration of one point mass in signed Q32.16.
//
//   channel | dir | handshake   | carries
//   cfg     | in  | valid/ready | register index, 48-bit data
//   cmd     | in  | valid/ready | command, force xyz, time step, trail index
//   res     | out | valid/ready | position, velocity, trail count, status
//
// A step item runs the restoring divider in each lane, the shared-multiplier
// states and the velocity and position updates, plus issue, merge and the
// output register load. Apply force and restart go from idle straight to
// emit; read trail passes through a state for the registered RAM read.
// rst is synchronous; the trail RAM is not cleared, entries are tracked by a
// head pointer and fill count. A new item is accepted while a result still
// waits on res; the next result then holds until res is taken.
// ----------------------------------------------------------------------------
module point_mass_euler_integrator (
  input  logic    clk,
  input  logic    rst,
  pme_cfg_if.sink cfg,
  pme_cmd_if.sink cmd,
  pme_res_if.source res
);
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_STEP = 4'b0010,
    S_RD   = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  localparam int AW = pme_pkg::TRAIL_AW;
  localparam int CW = pme_pkg::TRAIL_CW;
  localparam int SW = pme_pkg::SLOT_SW;
  localparam logic [SW-1:0] DEPTH_S = SW'(pme_pkg::TRAIL_DEPTH);
  localparam logic [CW-1:0] DEPTH_C = CW'(pme_pkg::TRAIL_DEPTH);

  state_t state;

  // configuration
  logic signed [47:0] init_pos [3];
  logic signed [47:0] init_vel [3];
  logic [47:0]        mass;
  logic               active;

  // body state
  logic signed [47:0] fsum [3];
  logic signed [47:0] pos  [3];
  logic signed [47:0] vel  [3];
  logic [AW-1:0]      head;
  logic [CW-1:0]      fill;

  // staged result
  logic signed [47:0] shown [3];
  pme_pkg::status_t   st;
  logic               res_valid;
  logic               emit;

  // lanes
  logic                 lane_start;
  logic signed [47:0]   lane_f [3];
  logic signed [47:0]   lane_v [3];
  logic signed [47:0]   lane_p [3];
  pme_pkg::lane_stat_t  lane_st [3];
  logic                 all_done;
  logic                 any_sat;

  // trail RAM
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic [pme_pkg::TRAIL_W-1:0] ram_wdata;
  logic [AW-1:0]              ram_raddr;
  logic [pme_pkg::TRAIL_W-1:0] ram_rdata;

  logic               accept;
  pme_pkg::cmd_t      cmd_code;
  logic signed [48:0] fadd [3];
  logic               fsat;
  logic [SW-1:0]      rd_sum;
  logic [SW-1:0]      push_sum;
  logic [AW-1:0]      push_slot;
  logic [AW-1:0]      head_inc;
  logic               rd_oor;

  assign cfg.ready = 1'b1;
  assign cmd.ready = (state == S_IDLE);
  assign accept    = cmd.valid && cmd.ready;
  assign cmd_code  = pme_pkg::cmd_t'(cmd.command);
  // output register loads when it is empty or being taken
  assign emit      = (state == S_EMIT) && (!res_valid || res.ready);

  always_comb begin
    fsat = 1'b0;
    for (int i = 0; i < 3; i++) begin
      fadd[i] = 49'(fsum[i]) + 49'(i == 0 ? cmd.force_x : (i == 1 ? cmd.force_y
                                                                   : cmd.force_z));
      fsat = fsat | pme_pkg::is_sat48(52'(fadd[i]));
    end
  end

  // trail slot arithmetic: all in-range sums stay below twice the depth
  assign rd_oor    = SW'(cmd.trail_index) >= SW'(fill);
  assign rd_sum    = SW'(head) + SW'(cmd.trail_index);
  assign ram_raddr = AW'((rd_sum >= DEPTH_S) ? rd_sum - DEPTH_S : rd_sum);
  assign push_sum  = SW'(head) + SW'(fill);
  assign push_slot = (fill < DEPTH_C) ?
                     AW'((push_sum >= DEPTH_S) ? push_sum - DEPTH_S : push_sum) : head;
  assign head_inc  = (SW'(head) + SW'(1) >= DEPTH_S) ? '0 : AW'(SW'(head) + SW'(1));

  assign all_done = lane_st[0].done && lane_st[1].done && lane_st[2].done;
  assign any_sat  = lane_st[0].sat || lane_st[1].sat || lane_st[2].sat;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = push_slot;
    ram_wdata = {lane_p[2], lane_p[1], lane_p[0]};
    if (state == S_IDLE && accept && cmd_code == pme_pkg::CMD_RESTART) begin
      ram_we    = 1'b1;
      ram_waddr = '0;
      ram_wdata = {init_pos[2], init_pos[1], init_pos[0]};
    end else if (state == S_STEP && all_done) begin
      ram_we = 1'b1;
    end
  end

  assign lane_start = (state == S_IDLE) && accept && cmd_code == pme_pkg::CMD_STEP &&
                      active && cmd.time_step != '0;
  assign lane_f = fsum;

  for (genvar g = 0; g < 3; g++) begin : g_lane
    pme_lane u_lane (
      .clk      (clk),
      .rst      (rst),
      .start    (lane_start),
      .force_in (lane_f[g]),
      .vel_in   (vel[g]),
      .pos_in   (pos[g]),
      .mass     (mass),
      .dt       (cmd.time_step),
      .vel_out  (lane_v[g]),
      .pos_out  (lane_p[g]),
      .stat     (lane_st[g])
    );
  end

  pme_ram #(.WIDTH(pme_pkg::TRAIL_W), .DEPTH(pme_pkg::TRAIL_DEPTH)) u_trail (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 3; i++) begin
        init_pos[i] <= '0;
        init_vel[i] <= '0;
      end
      mass   <= 48'd65536;
      active <= 1'b1;
    end else if (cfg.valid && cfg.ready) begin
      unique case (pme_pkg::reg_idx_t'(cfg.index))
        pme_pkg::REG_POS_X:  init_pos[0] <= cfg.data;
        pme_pkg::REG_POS_Y:  init_pos[1] <= cfg.data;
        pme_pkg::REG_POS_Z:  init_pos[2] <= cfg.data;
        pme_pkg::REG_VEL_X:  init_vel[0] <= cfg.data;
        pme_pkg::REG_VEL_Y:  init_vel[1] <= cfg.data;
        pme_pkg::REG_VEL_Z:  init_vel[2] <= cfg.data;
        pme_pkg::REG_MASS:   mass        <= cfg.data;
        pme_pkg::REG_ACTIVE: active      <= cfg.data[0];
      endcase
    end
  end

  // sequencer and body state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_valid <= 1'b0;
      head      <= '0;
      fill      <= '0;
      for (int i = 0; i < 3; i++) begin
        fsum[i] <= '0;
        pos[i]  <= '0;
        vel[i]  <= '0;
      end
    end else begin
      if (emit) res_valid <= 1'b1;
      else if (res.ready) res_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (cmd_code)
              pme_pkg::CMD_FORCE: begin
                for (int i = 0; i < 3; i++) fsum[i] <= pme_pkg::sat48(52'(fadd[i]));
                shown <= pos;
                if (fsat) st <= pme_pkg::ST_SAT;
                else st <= pme_pkg::ST_OK;
                state <= S_EMIT;
              end
              pme_pkg::CMD_STEP: begin
                shown <= pos;
                if (lane_start) begin
                  state <= S_STEP;
                end else begin
                  st    <= pme_pkg::ST_SKIP;
                  state <= S_EMIT;
                end
              end
              pme_pkg::CMD_READ: begin
                if (rd_oor) begin
                  for (int i = 0; i < 3; i++) shown[i] <= '0;
                  st    <= pme_pkg::ST_RANGE;
                  state <= S_EMIT;
                end else begin
                  st    <= pme_pkg::ST_OK;
                  state <= S_RD;
                end
              end
              pme_pkg::CMD_RESTART: begin
                pos   <= init_pos;
                vel   <= init_vel;
                shown <= init_pos;
                for (int i = 0; i < 3; i++) fsum[i] <= '0;
                head  <= '0;
                fill  <= CW'(1);
                st    <= pme_pkg::ST_OK;
                state <= S_EMIT;
              end
            endcase
          end
        end
        S_STEP: begin
          // merge the three lanes
          if (all_done) begin
            pos   <= lane_p;
            vel   <= lane_v;
            shown <= lane_p;
            for (int i = 0; i < 3; i++) fsum[i] <= '0;
            if (fill < DEPTH_C) fill <= fill + CW'(1);
            else head <= head_inc;
            if (any_sat) st <= pme_pkg::ST_SAT;
            else st <= pme_pkg::ST_OK;
            state <= S_EMIT;
          end
        end
        S_RD: begin
          shown[0] <= ram_rdata[47:0];
          shown[1] <= ram_rdata[95:48];
          shown[2] <= ram_rdata[143:96];
          state    <= S_EMIT;
        end
        S_EMIT: begin
          if (emit) begin
            res.pos_x       <= shown[0];
            res.pos_y       <= shown[1];
            res.pos_z       <= shown[2];
            res.vel_x       <= vel[0];
            res.vel_y       <= vel[1];
            res.vel_z       <= vel[2];
            res.trail_count <= 7'(fill);
            res.status      <= st;
            state           <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign res.valid = res_valid;
endmodule

>>> rtl/pme_checker.sv
// ----------------------------------------------------------------------------
// pme_checker
// Port-level checks on the result channel of the integrator.
// ----------------------------------------------------------------------------
module pme_checker (
  input logic              clk,
  input logic              rst,
  input logic              res_valid,
  input logic              res_ready,
  input logic signed [47:0] pos_x,
  input logic signed [47:0] pos_y,
  input logic signed [47:0] pos_z,
  input logic [6:0]        trail_count,
  input logic [1:0]        status
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_count: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> trail_count <= 7'(pme_pkg::TRAIL_DEPTH))
    else $error("trail count beyond depth");

  a_range_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && status == pme_pkg::ST_RANGE |->
      pos_x == '0 && pos_y == '0 && pos_z == '0)
    else $error("out-of-range read shows nonzero position");

  a_rst_idle: assert property (@(posedge clk)
    !rst && $past(rst) |-> !res_valid)
    else $error("result valid right after reset");
endmodule

bind point_mass_euler_integrator pme_checker u_pme_checker (
  .clk         (clk),
  .rst         (rst),
  .res_valid   (res.valid),
  .res_ready   (res.ready),
  .pos_x       (res.pos_x),
  .pos_y       (res.pos_y),
  .pos_z       (res.pos_z),
  .trail_count (res.trail_count),
  .status      (res.status)
);

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the point mass integrator: drives force, step,
// trail read and restart items under random stalls, predicts every result
// in fixed point and compares it field by field as it comes out.
// ----------------------------------------------------------------------------
module tb_top;

  localparam longint POS_MAX = 64'sh7FFF_FFFF_FFFF;
  localparam longint POS_MIN = -64'sh8000_0000_0000;
  localparam longint CAP = 64'sd1 << 49;

  typedef struct {
    longint  pos[3];
    longint  vel[3];
    int      count;
    pme_pkg::status_t st;
  } motion_t;

  // Integrator state mirror: predicts one result per accepted item.
  class motion_board;
    longint      init_pos[3], init_vel[3];
    logic [47:0] mass;
    bit          active;
    longint      fsum[3], pos[3], vel[3];
    longint      trail[pme_pkg::TRAIL_DEPTH][3];
    int          head, fill, errors;
    motion_t     pending[$];

    function new();
      mass = 48'd65536;
      active = 1;
      foreach (fsum[i]) begin
        init_pos[i] = 0; init_vel[i] = 0; fsum[i] = 0; pos[i] = 0; vel[i] = 0;
      end
      head = 0; fill = 0; errors = 0;
    endfunction

    function void write_reg(pme_pkg::reg_idx_t r, logic [47:0] d);
      case (r)
        pme_pkg::REG_POS_X, pme_pkg::REG_POS_Y, pme_pkg::REG_POS_Z:
          init_pos[int'(r)] = longint'($signed(d));
        pme_pkg::REG_VEL_X, pme_pkg::REG_VEL_Y, pme_pkg::REG_VEL_Z:
          init_vel[int'(r) - 3] = longint'($signed(d));
        pme_pkg::REG_MASS: mass = d;
        pme_pkg::REG_ACTIVE: active = d[0];
      endcase
    endfunction

    function longint clip(longint x, inout bit sat);
      if (x > POS_MAX) begin sat = 1; return POS_MAX; end
      if (x < POS_MIN) begin sat = 1; return POS_MIN; end
      return x;
    endfunction

    function logic [63:0] magn(longint x);
      return x < 0 ? 64'(-x) : 64'(x);
    endfunction

    // (a * dt) >> 16, capped at 2^49
    function longint scaled(logic [63:0] a, logic [31:0] dt);
      logic [95:0] p;
      p = ({32'd0, a} * {64'd0, dt}) >> 16;
      return (p > 96'(CAP)) ? CAP : longint'(p[63:0]);
    endfunction

    function void push_trail();
      int slot;
      if (fill < pme_pkg::TRAIL_DEPTH) begin
        slot = (head + fill) % pme_pkg::TRAIL_DEPTH;
        fill++;
      end else begin
        slot = head;
        head = (head + 1) % pme_pkg::TRAIL_DEPTH;
      end
      foreach (pos[i]) trail[slot][i] = pos[i];
    endfunction

    function void note_item(pme_pkg::cmd_t c, longint f[3], logic [31:0] dt,
                            logic [6:0] idx);
      motion_t     e;
      bit          sat;
      logic [63:0] amag;
      longint      d;
      sat = 0;
      e.st = pme_pkg::ST_OK;
      case (c)
        pme_pkg::CMD_FORCE: begin
          foreach (fsum[i]) fsum[i] = clip(fsum[i] + f[i], sat);
          foreach (pos[i]) e.pos[i] = pos[i];
        end
        pme_pkg::CMD_STEP: begin
          if (!active || dt == 0) begin
            e.st = pme_pkg::ST_SKIP;
          end else begin
            for (int i = 0; i < 3; i++) begin
              amag = (mass == 0) ? 64'd0 : (magn(fsum[i]) << 16) / {16'd0, mass};
              d = scaled(amag, dt);
              vel[i] = clip(vel[i] + (fsum[i] < 0 ? -d : d), sat);
              d = scaled(magn(vel[i]), dt);
              pos[i] = clip(pos[i] + (vel[i] < 0 ? -d : d), sat);
            end
            push_trail();
            foreach (fsum[i]) fsum[i] = 0;
          end
          foreach (pos[i]) e.pos[i] = pos[i];
        end
        pme_pkg::CMD_READ: begin
          if (idx >= fill) begin
            e.st = pme_pkg::ST_RANGE;
            foreach (pos[i]) e.pos[i] = 0;
          end else begin
            foreach (pos[i]) e.pos[i] = trail[(head + idx) % pme_pkg::TRAIL_DEPTH][i];
          end
        end
        pme_pkg::CMD_RESTART: begin
          foreach (pos[i]) begin
            pos[i] = init_pos[i]; vel[i] = init_vel[i]; fsum[i] = 0;
          end
          head = 0; fill = 0;
          push_trail();
          foreach (pos[i]) e.pos[i] = pos[i];
        end
      endcase
      if (sat) e.st = pme_pkg::ST_SAT;
      foreach (vel[i]) e.vel[i] = vel[i];
      e.count = fill;
      pending = {pending, e};
    endfunction

    function void check_result(motion_t a);
      motion_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result, pos %0d %0d %0d status %0d",
                 $time, a.pos[0], a.pos[1], a.pos[2], a.st);
        errors++;
        return;
      end
      e = pending.pop_front();
      for (int i = 0; i < 3; i++) begin
        if (a.pos[i] != e.pos[i]) begin
          $display("%0t: pos[%0d] expected %0d actual %0d", $time, i, e.pos[i], a.pos[i]);
          errors++;
        end
        if (a.vel[i] != e.vel[i]) begin
          $display("%0t: vel[%0d] expected %0d actual %0d", $time, i, e.vel[i], a.vel[i]);
          errors++;
        end
      end
      if (a.count != e.count) begin
        $display("%0t: trail_count expected %0d actual %0d", $time, e.count, a.count);
        errors++;
      end
      if (a.st != e.st) begin
        $display("%0t: status expected %0d actual %0d", $time, e.st, a.st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  always #1 clk = ~clk;

  pme_cfg_if cfg ();
  pme_cmd_if cmd ();
  pme_res_if res ();

  point_mass_euler_integrator u_top (
    .clk (clk),
    .rst (rst),
    .cfg (cfg.sink),
    .cmd (cmd.sink),
    .res (res.source)
  );

  motion_board board = new();

  // idle odds in percent, per side
  int send_gap = 8;
  int take_gap = 67;

  initial begin
    cfg.valid = 0; cfg.index = '0; cfg.data = '0;
    cmd.valid = 0; cmd.command = '0; cmd.force_x = '0; cmd.force_y = '0;
    cmd.force_z = '0; cmd.time_step = '0; cmd.trail_index = '0;
    res.ready = 0;
  end

  // Result side: ready changes at the falling edge; an item counts when
  // valid and ready are both up just ahead of the rising edge.
  always begin
    motion_t got;
    @(negedge clk);
    res.ready = !rst && ($urandom_range(0, 99) >= take_gap);
    #0.5;
    if (res.valid && res.ready) begin
      got.pos[0] = res.pos_x; got.pos[1] = res.pos_y; got.pos[2] = res.pos_z;
      got.vel[0] = res.vel_x; got.vel[1] = res.vel_y; got.vel[2] = res.vel_z;
      got.count = res.trail_count;
      got.st = pme_pkg::status_t'(res.status);
      board.check_result(got);
    end
  end

  task automatic write_reg(pme_pkg::reg_idx_t r, logic [47:0] d);
    @(negedge clk);
    cfg.valid = 1; cfg.index = r; cfg.data = d;
    forever begin
      #0.5;
      if (cfg.ready) break;
      @(negedge clk);
    end
    board.write_reg(r, d);
    @(negedge clk);
    cfg.valid = 0;
  endtask

  task automatic send(pme_pkg::cmd_t c, longint fx, longint fy, longint fz,
                      logic [31:0] dt, logic [6:0] idx);
    longint f[3];
    f[0] = fx; f[1] = fy; f[2] = fz;
    @(negedge clk);
    while ($urandom_range(0, 99) < send_gap) begin
      cmd.valid = 0;
      @(negedge clk);
    end
    cmd.valid = 1; cmd.command = c;
    cmd.force_x = fx[47:0]; cmd.force_y = fy[47:0]; cmd.force_z = fz[47:0];
    cmd.time_step = dt; cmd.trail_index = idx;
    forever begin
      #0.5;
      if (cmd.ready) break;
      @(negedge clk);
    end
    board.note_item(c, f, dt, idx);
    @(posedge clk);
  endtask

  // registers only change with nothing in flight
  task automatic drain();
    @(negedge clk);
    cmd.valid = 0;
    while (board.pending.size() != 0) @(negedge clk);
  endtask

  function automatic longint wide48();
    return longint'($signed({$urandom(), $urandom()} & 64'hFFFF_FFFF_FFFF) <<< 16) >>> 16;
  endfunction

  // mostly modest forces so motion stays in range, sometimes anything
  function automatic longint pick_force();
    case ($urandom_range(0, 9))
      0, 1: return wide48();
      2: return $urandom_range(0, 1) ? POS_MAX : POS_MIN;
      default: return longint'($urandom_range(0, 1 << 24)) - (1 << 23);
    endcase
  endfunction

  function automatic logic [31:0] pick_dt();
    case ($urandom_range(0, 19))
      0: return 32'd0;
      1: return $urandom();
      default: return $urandom_range(1, 1 << 17);
    endcase
  endfunction

  function automatic logic [6:0] pick_index();
    if (board.fill > 0 && $urandom_range(0, 9) != 0)
      return 7'($urandom_range(0, board.fill - 1));
    return 7'($urandom_range(0, 127));
  endfunction

  task automatic random_items(int n);
    int roll;
    for (int k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)
        send(pme_pkg::CMD_FORCE, pick_force(), pick_force(), pick_force(),
             $urandom(), 7'($urandom()));
      else if (roll < 70)
        send(pme_pkg::CMD_STEP, wide48(), wide48(), wide48(), pick_dt(),
             7'($urandom()));
      else if (roll < 95)
        send(pme_pkg::CMD_READ, wide48(), wide48(), wide48(), $urandom(),
             pick_index());
      else
        send(pme_pkg::CMD_RESTART, wide48(), wide48(), wide48(), $urandom(),
             7'($urandom()));
    end
  endtask

  function automatic logic [47:0] pick_start();
    case ($urandom_range(0, 5))
      0: return 48'h7FFF_FFFF_FFFF;
      1: return 48'h8000_0000_0000;
      2: return 48'(wide48());
      default: return 48'(longint'($urandom_range(0, 1 << 26)) - (1 << 25));
    endcase
  endfunction

  initial begin
    logic [47:0] masses[4];
    masses[0] = 48'd131072;
    masses[1] = 48'd0;
    masses[2] = 48'hFFFF_FFFF_FFFF;
    masses[3] = 48'd1;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // --- directed part: extremes and every special case ---
    write_reg(pme_pkg::REG_POS_X, 48'h7FFF_FFFF_FFFF);
    write_reg(pme_pkg::REG_POS_Y, 48'h8000_0000_0000);
    write_reg(pme_pkg::REG_POS_Z, 48'd0);
    write_reg(pme_pkg::REG_VEL_X, 48'h7FFF_FFFF_FFFF);
    write_reg(pme_pkg::REG_VEL_Y, 48'hFFFF_FFFF_0000);
    write_reg(pme_pkg::REG_VEL_Z, 48'd65536);
    write_reg(pme_pkg::REG_MASS, 48'd65536);
    write_reg(pme_pkg::REG_ACTIVE, 48'd1);
    send(pme_pkg::CMD_READ, 0, 0, 0, 0, 7'd0);              // empty trail after reset
    send(pme_pkg::CMD_STEP, 0, 0, 0, 32'h0001_0000, 7'd0);  // step from reset state
    send(pme_pkg::CMD_RESTART, 0, 0, 0, 0, 7'd0);
    send(pme_pkg::CMD_READ, 0, 0, 0, 0, 7'd0);
    send(pme_pkg::CMD_READ, 0, 0, 0, 0, 7'd1);              // past the fill count
    send(pme_pkg::CMD_READ, 0, 0, 0, 0, 7'd127);
    send(pme_pkg::CMD_FORCE, POS_MAX, POS_MAX, POS_MIN, 0, 7'd0);
    send(pme_pkg::CMD_FORCE, POS_MAX, 1, POS_MIN, 0, 7'd0);  // force sum saturates
    send(pme_pkg::CMD_STEP, 0, 0, 0, 32'd0, 7'd0);          // zero time step skips
    send(pme_pkg::CMD_STEP, 0, 0, 0, 32'hFFFF_FFFF, 7'd0);  // velocity and position clip
    send(pme_pkg::CMD_STEP, 0, 0, 0, 32'd1, 7'd0);
    send(pme_pkg::CMD_READ, 0, 0, 0, 0, 7'd2);
    drain();
    write_reg(pme_pkg::REG_ACTIVE, 48'd0);
    send(pme_pkg::CMD_FORCE, 65536, -65536, 0, 0, 7'd0);
    send(pme_pkg::CMD_STEP, 0, 0, 0, 32'h0001_0000, 7'd0);  // inactive body skips
    drain();
    write_reg(pme_pkg::REG_ACTIVE, 48'd1);
    write_reg(pme_pkg::REG_MASS, 48'd0);
    send(pme_pkg::CMD_STEP, 0, 0, 0, 32'h0001_0000, 7'd0);  // zero mass: drift only
    send(pme_pkg::CMD_FORCE, -1, POS_MIN, 3, 0, 7'd0);
    send(pme_pkg::CMD_STEP, 0, 0, 0, 32'h0000_8000, 7'd0);
    send(pme_pkg::CMD_READ, 0, 0, 0, 0, 7'd3);

    // --- random phases: new settings each time, idling pattern by phase ---
    for (int p = 0; p < 4; p++) begin
      drain();
      send_gap = (p == 0) ? 8 : (p == 1) ? 67 : 0;
      take_gap = (p == 0) ? 67 : (p == 1) ? 8 : 0;
      write_reg(pme_pkg::REG_POS_X, pick_start());
      write_reg(pme_pkg::REG_POS_Y, pick_start());
      write_reg(pme_pkg::REG_POS_Z, pick_start());
      write_reg(pme_pkg::REG_VEL_X, pick_start());
      write_reg(pme_pkg::REG_VEL_Y, pick_start());
      write_reg(pme_pkg::REG_VEL_Z, pick_start());
      write_reg(pme_pkg::REG_MASS,
                (p == 3) ? 48'($urandom_range(1, 1 << 20)) : masses[p]);
      write_reg(pme_pkg::REG_ACTIVE, 48'd1);
      send(pme_pkg::CMD_RESTART, 0, 0, 0, 0, 7'd0);
      random_items(470);
    end

    drain();
    repeat (100) @(posedge clk);
    if (board.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #8000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
rtl/pme_pkg.sv
rtl/pme_ifs.sv
rtl/pme_ram.sv
rtl/pme_lane.sv
rtl/point_mass_euler_integrator.sv
rtl/pme_checker.sv
tb/sv/tb_top.sv
